// ===== src/bba_pkg.sv =====
// Shared types, constants and helper functions for the bitmap block allocator.
// Has no dependencies. Every other file in the project depends on it.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int NUM_BLOCKS = 64;
	localparam int MAX_RUN    = 64;
	localparam int ID_W       = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = 7;
	localparam int REL_W      = 7;
	localparam int STATUS_W   = 2;
	localparam int Q_DEPTH    = 2;
	localparam int QPTR_W     = $clog2(Q_DEPTH);
	localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [2:0] {
		OP_ALLOC,
		OP_EMPTY,
		OP_OVERSIZE,
		OP_FREE,
		OP_FREE_BAD
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [CNT_W-1:0] count;
		logic [ID_W-1:0]  id;
	} job_t;

	typedef struct packed {
		logic [ID_W-1:0]     granted_id;
		logic                id_valid;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    free_count;
		logic                run_last;
	} result_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_ctl_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	function automatic logic [ID_W-1:0] bba_encode(input logic [NUM_BLOCKS-1:0] onehot);
		logic [ID_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			if (onehot[i]) begin
				idx = idx | ID_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ===== src/bba_ifs.sv =====
// Handshake interfaces for the command and result channels of the allocator.
// Depends on bba_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface bba_cmd_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        command;
	logic [bba_pkg::CNT_W-1:0]                   request_count;
	logic signed [bba_pkg::REL_W-1:0]            release_id;
	logic                                        list_end;

	modport source (output valid, command, request_count, release_id, list_end, input ready);
	modport sink (input valid, command, request_count, release_id, list_end, output ready);
endinterface

interface bba_res_if;
	logic                                        valid;
	logic                                        ready;
	logic [bba_pkg::ID_W-1:0]                    granted_id;
	logic                                        id_valid;
	logic [bba_pkg::STATUS_W-1:0]                status;
	logic [bba_pkg::CNT_W-1:0]                   free_count;
	logic                                        run_last;

	modport source (output valid, granted_id, id_valid, status, free_count, run_last,
		input ready);
	modport sink (input valid, granted_id, id_valid, status, free_count, run_last,
		output ready);
endinterface
`default_nettype wire

// ===== src/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, the channel interfaces, bba_front, bba_queue and bba_back.
`timescale 1ns / 1ps
`default_nettype none
// The allocator keeps one occupancy bit for each of 64 blocks and a count of free
// blocks. Commands enter through a front end that sorts them and a two-entry queue, so a
// command is taken while the back end is still busy or a result waits to be taken. The
// back end answers each free command, failed or empty allocation with one result when it
// takes the job. After taking an allocation of N blocks, it grants one id a cycle while
// the result slot is free, each from a single lowest-free-block search over the map.
// Each result reports the free count after it; the last of a command carries run_last.
module bitmap_block_allocator (
	input  logic      clk,
	input  logic      arst_n,
	bba_cmd_if.sink   cmd,
	bba_res_if.source res
);
	import bba_pkg::*;

	logic    push;
	logic    q_full;
	logic    q_empty;
	job_t    push_job;
	job_t    head_job;
	q_ctl_t  q_ctl;

	bba_front u_front (
		.cmd    (cmd),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	bba_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.ctl_in   (q_ctl),
		.empty    (q_empty),
		.head     (head_job)
	);

	bba_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (head_job),
		.q_empty (q_empty),
		.q_ctl   (q_ctl),
		.res     (res)
	);
endmodule
`default_nettype wire

// ===== src/bba_front.sv =====
// Front end: takes command transfers and sorts them into job kinds for the queue.
// Depends on bba_pkg and the command interface.
`timescale 1ns / 1ps
`default_nettype none
module bba_front (
	bba_cmd_if.sink          cmd,
	input  logic             q_full,
	output logic             push,
	output bba_pkg::job_t    job
);
	import bba_pkg::*;

	logic [REL_W-1:0] rel_u;
	logic             rel_bad;

	assign cmd.ready = !q_full;
	assign push      = cmd.valid && !q_full;
	assign rel_u     = unsigned'(cmd.release_id);
	assign rel_bad   = rel_u[REL_W-1] || (rel_u >= REL_W'(NUM_BLOCKS));

	always_comb begin
		job.count = cmd.request_count;
		job.id    = rel_u[ID_W-1:0];
		if (cmd.command == CMD_FREE) begin
			job.kind = rel_bad ? OP_FREE_BAD : OP_FREE;
		end else if (cmd.request_count > CNT_W'(MAX_RUN)) begin
			job.kind = OP_OVERSIZE;
		end else if (cmd.request_count == '0) begin
			job.kind = OP_EMPTY;
		end else begin
			job.kind = OP_ALLOC;
		end
	end
endmodule
`default_nettype wire

// ===== src/bba_queue.sv =====
// Short job queue that decouples the front end from the back end.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bba_pkg::job_t    push_job,
	output logic             full,
	input  bba_pkg::q_ctl_t  ctl_in,
	output logic             empty,
	output bba_pkg::job_t    head
);
	import bba_pkg::*;

	job_t              slots_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] used_q;
	logic              do_pop;

	assign full   = (used_q == QCNT_W'(Q_DEPTH));
	assign empty  = (used_q == '0);
	assign do_pop = ctl_in.pop && !ctl_in.empty;
	assign head   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				used_q <= used_q + 1'b1;
			end else if (do_pop && !push) begin
				used_q <= used_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end
endmodule
`default_nettype wire

// ===== src/bba_back.sv =====
// Back end: holds the occupancy map and free count, grants one block per cycle while the result slot is free.
// Depends on bba_pkg and the result interface.
`timescale 1ns / 1ps
`default_nettype none
module bba_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bba_pkg::job_t    job,
	input  logic             q_empty,
	output bba_pkg::q_ctl_t  q_ctl,
	bba_res_if.source        res
);
	import bba_pkg::*;

	bk_state_t            state_q, state_d;
	logic [NUM_BLOCKS-1:0] occ_q, occ_d;
	logic [CNT_W-1:0]     free_q, free_d;
	logic [CNT_W-1:0]     remain_q, remain_d;
	logic                 res_valid_q, res_valid_d;
	result_t              res_q, res_d;
	logic                 slot_free;
	logic                 take;
	logic                 emit;
	logic [NUM_BLOCKS-1:0] vacant;
	logic [NUM_BLOCKS-1:0] lowest;
	logic [ID_W-1:0]      lowest_id;

	assign slot_free = !res_valid_q || res.ready;
	assign take      = (state_q == BK_IDLE) && !q_empty && slot_free;
	assign vacant    = ~occ_q;
	assign lowest    = vacant & (~vacant + 1'b1);
	assign lowest_id = bba_encode(lowest);

	assign q_ctl.pop   = take;
	assign q_ctl.empty = q_empty;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take && job.kind == OP_ALLOC && job.count <= free_q) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (slot_free && remain_q == CNT_W'(1)) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		occ_d    = occ_q;
		free_d   = free_q;
		remain_d = remain_q;
		emit     = 1'b0;
		res_d    = '{granted_id: '0, id_valid: 1'b0, status: ST_OK,
			free_count: free_q, run_last: 1'b1};
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					case (job.kind)
						OP_ALLOC: begin
							if (job.count > free_q) begin
								emit         = 1'b1;
								res_d.status = ST_SHORT;
							end else begin
								remain_d = job.count;
							end
						end
						OP_EMPTY: emit = 1'b1;
						OP_OVERSIZE: begin
							emit         = 1'b1;
							res_d.status = ST_SHORT;
						end
						OP_FREE: begin
							emit = 1'b1;
							if (occ_q[job.id]) begin
								occ_d[job.id]    = 1'b0;
								free_d           = free_q + 1'b1;
								res_d.free_count = free_q + 1'b1;
							end
						end
						OP_FREE_BAD: begin
							emit         = 1'b1;
							res_d.status = ST_IGNORED;
						end
						default: emit = 1'b0;
					endcase
				end
			end
			BK_RUN: begin
				if (slot_free) begin
					emit             = 1'b1;
					occ_d            = occ_q | lowest;
					free_d           = free_q - 1'b1;
					remain_d         = remain_q - 1'b1;
					res_d.granted_id = lowest_id;
					res_d.id_valid   = 1'b1;
					res_d.free_count = free_q - 1'b1;
					res_d.run_last   = (remain_q == CNT_W'(1));
				end
			end
			default: emit = 1'b0;
		endcase
		if (emit) begin
			res_valid_d = 1'b1;
		end else if (res.ready) begin
			res_valid_d = 1'b0;
		end else begin
			res_valid_d = res_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			occ_q       <= '0;
			free_q      <= CNT_W'(NUM_BLOCKS);
			remain_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			free_q      <= free_d;
			remain_q    <= remain_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.granted_id = res_q.granted_id;
	assign res.id_valid   = res_q.id_valid;
	assign res.status     = res_q.status;
	assign res.free_count = res_q.free_count;
	assign res.run_last   = res_q.run_last;
endmodule
`default_nettype wire

// ===== src/bba_checker.sv =====
// Port-level checks on the allocator's result channel, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator.
`timescale 1ns / 1ps
`default_nettype none
module bba_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [bba_pkg::ID_W-1:0]       granted_id,
	input logic                           id_valid,
	input logic [bba_pkg::STATUS_W-1:0]   status,
	input logic [bba_pkg::CNT_W-1:0]      free_count,
	input logic                           run_last
);
	import bba_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(granted_id) && $stable(free_count)
		&& $stable(status) && $stable(run_last))
		else $error("result changed while stalled");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && id_valid |-> status == ST_OK)
		else $error("granted block with failure status");

	a_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !id_valid |-> granted_id == '0 && run_last)
		else $error("result without block carries an id or is not last");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> free_count <= CNT_W'(NUM_BLOCKS))
		else $error("free count above block total");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == ST_SHORT || status == ST_IGNORED) |-> !id_valid && run_last)
		else $error("failed command shaped wrongly");
endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.granted_id (res.granted_id),
	.id_valid   (res.id_valid),
	.status     (res.status),
	.free_count (res.free_count),
	.run_last   (res.run_last)
);
`default_nettype wire
